### hw/rtl/c8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_pkg
// Shared constants, opcode codes, micro-op codes, status type and font table
// for the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int ADDR_W      = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int FB_ROWS     = 32;
  localparam int FB_COLS     = 64;
  localparam int ROW_W       = $clog2(FB_ROWS);
  localparam int COL_W       = $clog2(FB_COLS);
  localparam int NREG        = 16;
  localparam int REG_AW      = $clog2(NREG);
  localparam int FONT_LEN    = 80;

  localparam logic [ADDR_W-1:0] PC_START  = 12'h200;
  localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;
  localparam logic [REG_AW-1:0] REG_FLAG  = 4'hF;

  // item operations
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;

  // opcode groups (top nibble)
  localparam logic [3:0] G_SYS  = 4'h0;
  localparam logic [3:0] G_JP   = 4'h1;
  localparam logic [3:0] G_CALL = 4'h2;
  localparam logic [3:0] G_SEQ  = 4'h3;
  localparam logic [3:0] G_SNE  = 4'h4;
  localparam logic [3:0] G_SEQR = 4'h5;
  localparam logic [3:0] G_LD   = 4'h6;
  localparam logic [3:0] G_ADD  = 4'h7;
  localparam logic [3:0] G_ALU  = 4'h8;
  localparam logic [3:0] G_SNER = 4'h9;
  localparam logic [3:0] G_LDI  = 4'hA;
  localparam logic [3:0] G_JPV  = 4'hB;
  localparam logic [3:0] G_RND  = 4'hC;
  localparam logic [3:0] G_DRW  = 4'hD;
  localparam logic [3:0] G_KEY  = 4'hE;
  localparam logic [3:0] G_MISC = 4'hF;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  // 8XYN sub-operations
  localparam logic [3:0] A_MOV  = 4'h0;
  localparam logic [3:0] A_OR   = 4'h1;
  localparam logic [3:0] A_AND  = 4'h2;
  localparam logic [3:0] A_XOR  = 4'h3;
  localparam logic [3:0] A_ADD  = 4'h4;
  localparam logic [3:0] A_SUB  = 4'h5;
  localparam logic [3:0] A_SHR  = 4'h6;
  localparam logic [3:0] A_SUBN = 4'h7;
  localparam logic [3:0] A_SHL  = 4'hE;

  // EXNN / FXNN sub-operations
  localparam logic [7:0] K_SKP  = 8'h9E;
  localparam logic [7:0] K_SKNP = 8'hA1;
  localparam logic [7:0] M_GDT  = 8'h07;
  localparam logic [7:0] M_WKEY = 8'h0A;
  localparam logic [7:0] M_SDT  = 8'h15;
  localparam logic [7:0] M_SST  = 8'h18;
  localparam logic [7:0] M_ADDI = 8'h1E;
  localparam logic [7:0] M_FONT = 8'h29;
  localparam logic [7:0] M_BCD  = 8'h33;
  localparam logic [7:0] M_STR  = 8'h55;
  localparam logic [7:0] M_LDR  = 8'h65;

  // datapath micro-ops
  typedef logic [4:0] uop_t;
  localparam uop_t U_NOP    = 5'd0;
  localparam uop_t U_CLR    = 5'd1;
  localparam uop_t U_LATCH  = 5'd2;
  localparam uop_t U_WRB    = 5'd3;
  localparam uop_t U_F0     = 5'd4;
  localparam uop_t U_F1     = 5'd5;
  localparam uop_t U_F2     = 5'd6;
  localparam uop_t U_RY     = 5'd7;
  localparam uop_t U_R0     = 5'd8;
  localparam uop_t U_CAP0   = 5'd9;
  localparam uop_t U_EXEC   = 5'd10;
  localparam uop_t U_VF     = 5'd11;
  localparam uop_t U_FBCLR  = 5'd12;
  localparam uop_t U_DMRD   = 5'd13;
  localparam uop_t U_DFRD   = 5'd14;
  localparam uop_t U_DWR    = 5'd15;
  localparam uop_t U_DVF    = 5'd16;
  localparam uop_t U_BCD    = 5'd17;
  localparam uop_t U_SRD    = 5'd18;
  localparam uop_t U_SWR    = 5'd19;
  localparam uop_t U_LRD    = 5'd20;
  localparam uop_t U_LWR    = 5'd21;
  localparam uop_t U_ROWRD  = 5'd22;
  localparam uop_t U_ROWCAP = 5'd23;
  localparam uop_t U_OUT    = 5'd24;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] opcode;
    logic        cnt_eq_n;
    logic        cnt_eq_x;
    logic        cnt_init_last;
    logic        cnt_row_last;
    logic        cnt_bcd_last;
  } c8_stat_t;

  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // reset contents of main memory at one address
  function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] d;
    begin
      d = a - FONT_BASE;
      if (a >= FONT_BASE && d < ADDR_W'(FONT_LEN)) return FONT[d[6:0]];
      return 8'h00;
    end
  endfunction

endpackage

### hw/rtl/chip8_instruction_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 processor core: program byte writes, single-instruction execute and
// display row reads, one result word per input word.
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// in_*     in   in_valid / in_stall   operation, address, data, keys,
//                                     random_byte, row
// out_*    out  out_valid / out_stall row_pixels, program_counter, flags
//
// Execute adds a loop for 00E0, DXYN, FX33 and FX55/FX65, and a VF write for
// flag-writing 8XY ops; each memory has a single read port. After reset main
// memory, frame buffer and V registers are swept with in_stall high. A new
// word is taken while a result waits in the output register; a stalled
// result holds the next one in the sequencer.
// ----------------------------------------------------------------------------
module chip8_instruction_core import c8_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic [7:0]         in_data,
  input  logic [15:0]        in_keys,
  input  logic [7:0]         in_random_byte,
  input  logic [ROW_W-1:0]   in_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FB_COLS-1:0] out_row_pixels,
  output logic [ADDR_W-1:0]  out_program_counter,
  output logic               out_draw_flag,
  output logic               out_waiting_for_key,
  output logic               out_bad_opcode,
  output logic               out_sound_on
);

  uop_t     uop;
  c8_stat_t stat;

  c8_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .uop       (uop)
  );

  c8_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .uop                 (uop),
    .stat                (stat),
    .in_operation        (in_operation),
    .in_address          (in_address),
    .in_data             (in_data),
    .in_keys             (in_keys),
    .in_random_byte      (in_random_byte),
    .in_row              (in_row),
    .out_row_pixels      (out_row_pixels),
    .out_program_counter (out_program_counter),
    .out_draw_flag       (out_draw_flag),
    .out_waiting_for_key (out_waiting_for_key),
    .out_bad_opcode      (out_bad_opcode),
    .out_sound_on        (out_sound_on)
  );

endmodule

### hw/rtl/c8_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/c8_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_dp
// Datapath: memories, architectural registers, instruction execute logic and
// the result register. Driven one micro-op per cycle by the controller.
// ----------------------------------------------------------------------------
module c8_dp import c8_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  uop_t              uop,
  output c8_stat_t          stat,
  input  logic [1:0]        in_operation,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [7:0]        in_data,
  input  logic [15:0]       in_keys,
  input  logic [7:0]        in_random_byte,
  input  logic [ROW_W-1:0]  in_row,
  output logic [FB_COLS-1:0] out_row_pixels,
  output logic [ADDR_W-1:0] out_program_counter,
  output logic              out_draw_flag,
  output logic              out_waiting_for_key,
  output logic              out_bad_opcode,
  output logic              out_sound_on
);

  // latched item
  logic [1:0]        op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        data_r, data_nxt;
  logic [15:0]       keys_r, keys_nxt;
  logic [7:0]        rnd_r, rnd_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  // per-item working registers
  logic [FB_COLS-1:0] pix_r, pix_nxt;
  logic               drew_r, drew_nxt, wait_r, wait_nxt, bad_r, bad_nxt;
  logic [15:0]        opc_r, opc_nxt;
  logic [7:0]         vx_r, vx_nxt, vy_r, vy_nxt, v0_r, v0_nxt, line_r, line_nxt;
  logic               hit_r, hit_nxt, flag_r, flag_nxt;

  // architectural state
  logic [ADDR_W-1:0]  pc_r, pc_nxt;
  logic [15:0]        i_r, i_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [ADDR_W-1:0]  stack_r [STACK_DEPTH];
  logic [ADDR_W-1:0]  stack_nxt [STACK_DEPTH];
  logic [7:0]         dt_r, dt_nxt, st_r, st_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;

  // result register
  logic [FB_COLS-1:0] o_pix_r, o_pix_nxt;
  logic [ADDR_W-1:0]  o_pc_r, o_pc_nxt;
  logic               o_drew_r, o_drew_nxt, o_wait_r, o_wait_nxt, o_bad_r, o_bad_nxt;
  logic               o_snd_r, o_snd_nxt;

  // memory ports
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [7:0]         mem_wdata, mem_rdata;
  logic               fb_we;
  logic [ROW_W-1:0]   fb_waddr, fb_raddr;
  logic [FB_COLS-1:0] fb_wdata, fb_rdata;
  logic               v_we;
  logic [REG_AW-1:0]  v_waddr, v_raddr;
  logic [7:0]         v_wdata, v_rdata;

  // decode fields
  logic [3:0]         hi, x, y, n;
  logic [7:0]         nn;
  logic [ADDR_W-1:0]  nnn;
  logic [ADDR_W-1:0]  i_off;
  logic [ROW_W-1:0]   yy;
  logic [7:0]         spr;
  logic [FB_COLS-1:0] spr_wide, mask;

  // execute results
  logic [ADDR_W-1:0]  ex_pc, pc_next, pc_skip;
  logic [7:0]         ex_v;
  logic               ex_vwe, ex_flag, ex_drew, ex_wait, ex_bad, ex_push;
  logic [15:0]        ex_i;
  logic [SP_W-1:0]    ex_sp, sp_dec, sp_inc;
  logic [7:0]         ex_dt, ex_st;
  logic [8:0]         sum9;
  logic               key_dn;
  logic [3:0]         key_hi;

  // decimal digits
  logic [1:0]         hund;
  logic [7:0]         rem8, hsub, ones8;
  logic [14:0]        tprod;
  logic [3:0]         tens;
  logic [7:0]         bcd_digit;

  assign hi  = opc_r[15:12];
  assign x   = opc_r[11:8];
  assign y   = opc_r[7:4];
  assign n   = opc_r[3:0];
  assign nn  = opc_r[7:0];
  assign nnn = opc_r[ADDR_W-1:0];
  assign i_off = i_r[ADDR_W-1:0] + cnt_r;
  assign yy    = vy_r[ROW_W-1:0] + cnt_r[ROW_W-1:0];

  // sprite byte: msb is leftmost pixel, rotated onto the row at column VX
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      spr[c] = line_r[7-c];
    end
    spr_wide = {{(FB_COLS-8){1'b0}}, spr};
    mask = (spr_wide << vx_r[COL_W-1:0]) |
           (spr_wide >> (7'(FB_COLS) - {1'b0, vx_r[COL_W-1:0]}));
  end

  // FX33 digits; tens via reciprocal multiply, valid for remainders below 100
  always_comb begin
    hund  = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
    hsub  = (hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0);
    rem8  = vx_r - hsub;
    tprod = 15'(rem8[6:0]) * 15'd205;
    tens  = tprod[14:11];
    ones8 = rem8 - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};
    case (cnt_r[1:0])
      2'd0:    bcd_digit = {6'b0, hund};
      2'd1:    bcd_digit = {4'b0, tens};
      default: bcd_digit = {4'b0, ones8[3:0]};
    endcase
  end

  // instruction execute
  always_comb begin
    pc_next = pc_r + 12'd2;
    pc_skip = pc_r + 12'd4;
    sp_dec  = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - 1'b1;
    sp_inc  = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
    sum9    = {1'b0, vx_r} + {1'b0, vy_r};
    key_dn  = keys_r[vx_r[3:0]];
    key_hi  = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (keys_r[k]) key_hi = 4'(k);
    end
    ex_pc   = pc_next;
    ex_v    = 8'h00;
    ex_vwe  = 1'b0;
    ex_flag = 1'b0;
    ex_i    = i_r;
    ex_sp   = sp_r;
    ex_push = 1'b0;
    ex_dt   = dt_r;
    ex_st   = st_r;
    ex_drew = 1'b0;
    ex_wait = 1'b0;
    ex_bad  = 1'b0;
    case (hi)
      G_SYS: begin
        if (opc_r == OPC_CLS) begin
          ex_drew = 1'b1;
        end else if (opc_r == OPC_RET) begin
          ex_sp = sp_dec;
          ex_pc = stack_r[sp_dec] + 12'd2;
        end else begin
          ex_bad = 1'b1;
        end
      end
      G_JP: ex_pc = nnn;
      G_CALL: begin
        ex_push = 1'b1;
        ex_sp   = sp_inc;
        ex_pc   = nnn;
      end
      G_SEQ:  ex_pc = (vx_r == nn) ? pc_skip : pc_next;
      G_SNE:  ex_pc = (vx_r != nn) ? pc_skip : pc_next;
      G_SEQR: ex_pc = (vx_r == vy_r) ? pc_skip : pc_next;
      G_SNER: ex_pc = (vx_r != vy_r) ? pc_skip : pc_next;
      G_LD: begin
        ex_vwe = 1'b1;
        ex_v   = nn;
      end
      G_ADD: begin
        ex_vwe = 1'b1;
        ex_v   = vx_r + nn;
      end
      G_ALU: begin
        ex_vwe = 1'b1;
        case (n)
          A_MOV: ex_v = vy_r;
          A_OR:  ex_v = vx_r | vy_r;
          A_AND: ex_v = vx_r & vy_r;
          A_XOR: ex_v = vx_r ^ vy_r;
          A_ADD: begin
            ex_v    = sum9[7:0];
            ex_flag = sum9[8];
          end
          A_SUB: begin
            ex_v    = vx_r - vy_r;
            ex_flag = (vx_r >= vy_r);
          end
          A_SHR: begin
            ex_v    = {1'b0, vx_r[7:1]};
            ex_flag = vx_r[0];
          end
          A_SUBN: begin
            ex_v    = vy_r - vx_r;
            ex_flag = (vy_r >= vx_r);
          end
          A_SHL: begin
            ex_v    = {vx_r[6:0], 1'b0};
            ex_flag = vx_r[7];
          end
          default: begin
            ex_vwe = 1'b0;
            ex_bad = 1'b1;
          end
        endcase
      end
      G_LDI: ex_i = {{(16-ADDR_W){1'b0}}, nnn};
      G_JPV: ex_pc = nnn + {{(ADDR_W-8){1'b0}}, v0_r};
      G_RND: begin
        ex_vwe = 1'b1;
        ex_v   = rnd_r & nn;
      end
      G_DRW: ex_drew = 1'b1;
      G_KEY: begin
        case (nn)
          K_SKP:   ex_pc = key_dn ? pc_skip : pc_next;
          K_SKNP:  ex_pc = key_dn ? pc_next : pc_skip;
          default: ex_bad = 1'b1;
        endcase
      end
      default: begin
        case (nn)
          M_GDT: begin
            ex_vwe = 1'b1;
            ex_v   = dt_r;
          end
          M_WKEY: begin
            if (keys_r == 16'h0000) begin
              ex_wait = 1'b1;
              ex_pc   = pc_r;
            end else begin
              ex_vwe = 1'b1;
              ex_v   = {4'b0, key_hi};
            end
          end
          M_SDT:  ex_dt = vx_r;
          M_SST:  ex_st = vx_r;
          M_ADDI: ex_i  = i_r + {8'b0, vx_r};
          M_FONT: ex_i  = {6'b0, vx_r, 2'b00} + {8'b0, vx_r} +
                          {{(16-ADDR_W){1'b0}}, FONT_BASE};
          M_BCD, M_STR, M_LDR: ex_bad = 1'b0;
          default: ex_bad = 1'b1;
        endcase
      end
    endcase
    if (ex_bad) ex_pc = pc_r;
  end

  // memory port muxing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_off;
    mem_wdata = v_rdata;
    mem_raddr = pc_r;
    fb_we     = 1'b0;
    fb_waddr  = yy;
    fb_wdata  = fb_rdata ^ mask;
    fb_raddr  = row_r;
    v_we      = 1'b0;
    v_waddr   = x;
    v_wdata   = ex_v;
    v_raddr   = x;
    case (uop)
      U_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = font_byte(cnt_r);
        fb_we     = 1'b1;
        fb_waddr  = cnt_r[ROW_W-1:0];
        fb_wdata  = '0;
        v_we      = 1'b1;
        v_waddr   = cnt_r[REG_AW-1:0];
        v_wdata   = 8'h00;
      end
      U_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = data_r;
      end
      U_F0:  mem_raddr = pc_r;
      U_F1:  mem_raddr = pc_r + 12'd1;
      U_F2:  v_raddr = x;
      U_RY:  v_raddr = y;
      U_R0:  v_raddr = '0;
      U_EXEC: v_we = ex_vwe;
      U_VF: begin
        v_we    = 1'b1;
        v_waddr = REG_FLAG;
        v_wdata = {7'b0, flag_r};
      end
      U_FBCLR: begin
        fb_we    = 1'b1;
        fb_waddr = cnt_r[ROW_W-1:0];
        fb_wdata = '0;
      end
      U_DMRD: mem_raddr = i_off;
      U_DFRD: fb_raddr = yy;
      U_DWR:  fb_we = 1'b1;
      U_DVF: begin
        v_we    = 1'b1;
        v_waddr = REG_FLAG;
        v_wdata = {7'b0, hit_r};
      end
      U_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit;
      end
      U_SRD: v_raddr = cnt_r[REG_AW-1:0];
      U_SWR: mem_we = 1'b1;
      U_LRD: mem_raddr = i_off;
      U_LWR: begin
        v_we    = 1'b1;
        v_waddr = cnt_r[REG_AW-1:0];
        v_wdata = mem_rdata;
      end
      U_ROWRD: fb_raddr = row_r;
      default: v_we = 1'b0;
    endcase
  end

  // register updates
  always_comb begin
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    keys_nxt  = keys_r;
    rnd_nxt   = rnd_r;
    row_nxt   = row_r;
    pix_nxt   = pix_r;
    drew_nxt  = drew_r;
    wait_nxt  = wait_r;
    bad_nxt   = bad_r;
    opc_nxt   = opc_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    v0_nxt    = v0_r;
    line_nxt  = line_r;
    hit_nxt   = hit_r;
    flag_nxt  = flag_r;
    pc_nxt    = pc_r;
    i_nxt     = i_r;
    sp_nxt    = sp_r;
    stack_nxt = stack_r;
    dt_nxt    = dt_r;
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    o_pix_nxt  = o_pix_r;
    o_pc_nxt   = o_pc_r;
    o_drew_nxt = o_drew_r;
    o_wait_nxt = o_wait_r;
    o_bad_nxt  = o_bad_r;
    o_snd_nxt  = o_snd_r;
    case (uop)
      U_CLR, U_FBCLR, U_BCD, U_SWR, U_LWR: cnt_nxt = cnt_r + 1'b1;
      U_LATCH: begin
        op_nxt   = in_operation;
        addr_nxt = in_address;
        data_nxt = in_data;
        keys_nxt = in_keys;
        rnd_nxt  = in_random_byte;
        row_nxt  = in_row;
        pix_nxt  = '0;
        drew_nxt = 1'b0;
        wait_nxt = 1'b0;
        bad_nxt  = 1'b0;
      end
      U_F1:   opc_nxt[15:8] = mem_rdata;
      U_F2:   opc_nxt[7:0]  = mem_rdata;
      U_RY:   vx_nxt = v_rdata;
      U_R0:   vy_nxt = v_rdata;
      U_CAP0: v0_nxt = v_rdata;
      U_EXEC: begin
        pc_nxt   = ex_pc;
        i_nxt    = ex_i;
        sp_nxt   = ex_sp;
        dt_nxt   = ex_dt;
        st_nxt   = ex_st;
        drew_nxt = ex_drew;
        wait_nxt = ex_wait;
        bad_nxt  = ex_bad;
        flag_nxt = ex_flag;
        hit_nxt  = 1'b0;
        cnt_nxt  = '0;
        if (ex_push) stack_nxt[sp_r] = pc_r;
      end
      U_DFRD: line_nxt = mem_rdata;
      U_DWR: begin
        hit_nxt = hit_r | (|(fb_rdata & mask));
        cnt_nxt = cnt_r + 1'b1;
      end
      U_ROWCAP: pix_nxt = fb_rdata;
      U_OUT: begin
        o_pix_nxt  = pix_r;
        o_pc_nxt   = pc_r;
        o_drew_nxt = drew_r;
        o_wait_nxt = wait_r;
        o_bad_nxt  = bad_r;
        o_snd_nxt  = (st_r != 8'h00);
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= PC_START;
      i_r     <= '0;
      sp_r    <= '0;
      dt_r    <= '0;
      st_r    <= '0;
      cnt_r   <= '0;
      for (int s = 0; s < STACK_DEPTH; s++) begin
        stack_r[s] <= '0;
      end
    end else begin
      pc_r    <= pc_nxt;
      i_r     <= i_nxt;
      sp_r    <= sp_nxt;
      dt_r    <= dt_nxt;
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      stack_r <= stack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    data_r   <= data_nxt;
    keys_r   <= keys_nxt;
    rnd_r    <= rnd_nxt;
    row_r    <= row_nxt;
    pix_r    <= pix_nxt;
    drew_r   <= drew_nxt;
    wait_r   <= wait_nxt;
    bad_r    <= bad_nxt;
    opc_r    <= opc_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    v0_r     <= v0_nxt;
    line_r   <= line_nxt;
    hit_r    <= hit_nxt;
    flag_r   <= flag_nxt;
    o_pix_r  <= o_pix_nxt;
    o_pc_r   <= o_pc_nxt;
    o_drew_r <= o_drew_nxt;
    o_wait_r <= o_wait_nxt;
    o_bad_r  <= o_bad_nxt;
    o_snd_r  <= o_snd_nxt;
  end

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  c8_ram #(.WIDTH(FB_COLS), .DEPTH(FB_ROWS)) u_fb (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  c8_ram #(.WIDTH(8), .DEPTH(NREG)) u_vreg (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  always_comb begin
    stat.operation     = op_r;
    stat.opcode        = opc_r;
    stat.cnt_eq_n      = (cnt_r == {{(ADDR_W-4){1'b0}}, n});
    stat.cnt_eq_x      = (cnt_r == {{(ADDR_W-4){1'b0}}, x});
    stat.cnt_init_last = (cnt_r == ADDR_W'(MEM_BYTES - 1));
    stat.cnt_row_last  = (cnt_r[ROW_W-1:0] == ROW_W'(FB_ROWS - 1));
    stat.cnt_bcd_last  = (cnt_r == 12'd2);
  end

  assign out_row_pixels      = o_pix_r;
  assign out_program_counter = o_pc_r;
  assign out_draw_flag       = o_drew_r;
  assign out_waiting_for_key = o_wait_r;
  assign out_bad_opcode      = o_bad_r;
  assign out_sound_on        = o_snd_r;

endmodule

### hw/rtl/c8_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_ctrl
// Sequencer: runs byte writes, row reads, and fetch, operand read, execute
// and the multi-cycle loops, issuing one datapath micro-op per cycle.
// ----------------------------------------------------------------------------
module c8_ctrl import c8_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  c8_stat_t stat,
  output uop_t     uop
);

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_F0     = 5'd3;
  localparam logic [4:0] S_F1     = 5'd4;
  localparam logic [4:0] S_F2     = 5'd5;
  localparam logic [4:0] S_RY     = 5'd6;
  localparam logic [4:0] S_R0     = 5'd7;
  localparam logic [4:0] S_CAP0   = 5'd8;
  localparam logic [4:0] S_EX     = 5'd9;
  localparam logic [4:0] S_VF     = 5'd10;
  localparam logic [4:0] S_FBCLR  = 5'd11;
  localparam logic [4:0] S_DCHK   = 5'd12;
  localparam logic [4:0] S_DMRD   = 5'd13;
  localparam logic [4:0] S_DFRD   = 5'd14;
  localparam logic [4:0] S_DWR    = 5'd15;
  localparam logic [4:0] S_DVF    = 5'd16;
  localparam logic [4:0] S_BCD    = 5'd17;
  localparam logic [4:0] S_SRD    = 5'd18;
  localparam logic [4:0] S_SWR    = 5'd19;
  localparam logic [4:0] S_LRD    = 5'd20;
  localparam logic [4:0] S_LWR    = 5'd21;
  localparam logic [4:0] S_ROWRD  = 5'd22;
  localparam logic [4:0] S_ROWCAP = 5'd23;
  localparam logic [4:0] S_DONE   = 5'd24;

  logic [4:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic [3:0] hi, n;
  logic [7:0] nn;

  assign hi = stat.opcode[15:12];
  assign n  = stat.opcode[3:0];
  assign nn = stat.opcode[7:0];

  always_comb begin
    state_nxt = state_r;
    uop       = U_NOP;
    ovld_nxt  = ovld_r && out_stall;
    case (state_r)
      S_INIT: begin
        uop = U_CLR;
        if (stat.cnt_init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          uop       = U_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.operation)
          OP_WRITE: begin
            uop       = U_WRB;
            state_nxt = S_DONE;
          end
          OP_EXEC: state_nxt = S_F0;
          OP_ROW:  state_nxt = S_ROWRD;
          default: state_nxt = S_DONE;
        endcase
      end
      S_F0: begin
        uop       = U_F0;
        state_nxt = S_F1;
      end
      S_F1: begin
        uop       = U_F1;
        state_nxt = S_F2;
      end
      S_F2: begin
        uop       = U_F2;
        state_nxt = S_RY;
      end
      S_RY: begin
        uop       = U_RY;
        state_nxt = S_R0;
      end
      S_R0: begin
        uop       = U_R0;
        state_nxt = S_CAP0;
      end
      S_CAP0: begin
        uop       = U_CAP0;
        state_nxt = S_EX;
      end
      S_EX: begin
        uop       = U_EXEC;
        state_nxt = S_DONE;
        if (stat.opcode == OPC_CLS) begin
          state_nxt = S_FBCLR;
        end else begin
          case (hi)
            G_ALU: begin
              if (n inside {A_ADD, A_SUB, A_SHR, A_SUBN, A_SHL}) state_nxt = S_VF;
            end
            G_DRW: state_nxt = S_DCHK;
            G_MISC: begin
              case (nn)
                M_BCD:   state_nxt = S_BCD;
                M_STR:   state_nxt = S_SRD;
                M_LDR:   state_nxt = S_LRD;
                default: state_nxt = S_DONE;
              endcase
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_VF: begin
        uop       = U_VF;
        state_nxt = S_DONE;
      end
      S_FBCLR: begin
        uop = U_FBCLR;
        if (stat.cnt_row_last) state_nxt = S_DONE;
      end
      // sprite: one memory row and one frame row per pass
      S_DCHK:  state_nxt = stat.cnt_eq_n ? S_DVF : S_DMRD;
      S_DMRD: begin
        uop       = U_DMRD;
        state_nxt = S_DFRD;
      end
      S_DFRD: begin
        uop       = U_DFRD;
        state_nxt = S_DWR;
      end
      S_DWR: begin
        uop       = U_DWR;
        state_nxt = S_DCHK;
      end
      S_DVF: begin
        uop       = U_DVF;
        state_nxt = S_DONE;
      end
      S_BCD: begin
        uop = U_BCD;
        if (stat.cnt_bcd_last) state_nxt = S_DONE;
      end
      S_SRD: begin
        uop       = U_SRD;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        uop       = U_SWR;
        state_nxt = stat.cnt_eq_x ? S_DONE : S_SRD;
      end
      S_LRD: begin
        uop       = U_LRD;
        state_nxt = S_LWR;
      end
      S_LWR: begin
        uop       = U_LWR;
        state_nxt = stat.cnt_eq_x ? S_DONE : S_LRD;
      end
      S_ROWRD: begin
        uop       = U_ROWRD;
        state_nxt = S_ROWCAP;
      end
      S_ROWCAP: begin
        uop       = U_ROWCAP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // result register free or draining this cycle
        if (!ovld_r || !out_stall) begin
          uop       = U_OUT;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovld_r;

endmodule

### hw/rtl/c8_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_chk
// Port-level checks for the CHIP-8 instruction core, bound to the top level.
// ----------------------------------------------------------------------------
module c8_chk import c8_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_operation,
  input logic [ADDR_W-1:0]  in_address,
  input logic [7:0]         in_data,
  input logic [15:0]        in_keys,
  input logic [7:0]         in_random_byte,
  input logic [ROW_W-1:0]   in_row,
  input logic               out_valid,
  input logic               out_stall,
  input logic [FB_COLS-1:0] out_row_pixels,
  input logic [ADDR_W-1:0]  out_program_counter,
  input logic               out_draw_flag,
  input logic               out_waiting_for_key,
  input logic               out_bad_opcode,
  input logic               out_sound_on
);

  // stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_program_counter))
    else $error("stalled result dropped or changed");

  // memory sweep after reset blocks input
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during reset sweep");

  // a new result only comes out of a busy cycle
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in flight");

  // status flags come from distinct instructions
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_draw_flag, out_waiting_for_key, out_bad_opcode}) <= 1)
    else $error("more than one status flag set");

endmodule

bind chip8_instruction_core c8_chk u_c8_chk (.*);

### bench/chip8_instruction_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core_tb
// Self-checking bench for the CHIP-8 core. A directed table covers reset
// state, field extremes, flag and wrap cases. A random part then loads
// instructions at the live program counter and executes them, mixed with row
// reads and stray writes. Result words are checked with a shadow core or,
// for typed table rows, a fixed word, under varied valid/stall pressure.
// ----------------------------------------------------------------------------
module chip8_instruction_core_tb;
  import c8_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 770;

  typedef struct packed {
    logic [63:0] pixels;
    logic [11:0] pc;
    logic        draw;
    logic        waiting;
    logic        bad;
    logic        sound;
  } status_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] opc;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  rb;
    logic [4:0]  row;
    bit          typed;
    logic [11:0] epc;
    bit          ebad;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic [ADDR_W-1:0] in_address = '0;
  logic [7:0] in_data = '0;
  logic [15:0] in_keys = '0;
  logic [7:0] in_random_byte = '0;
  logic [ROW_W-1:0] in_row = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [FB_COLS-1:0] out_row_pixels;
  logic [ADDR_W-1:0] out_program_counter;
  logic out_draw_flag, out_waiting_for_key, out_bad_opcode, out_sound_on;

  chip8_instruction_core u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow core state
  logic [7:0]  sh_mem [MEM_BYTES];
  logic [7:0]  sh_v [16];
  logic [11:0] sh_stack [STACK_DEPTH];
  logic [3:0]  sh_sp;
  logic [11:0] sh_pc;
  logic [15:0] sh_idx;
  logic [63:0] sh_fb [32];
  logic [7:0]  sh_delay, sh_sound;

  status_t status_due[$];
  int tx_idle_pct = 0, rx_idle_pct = 0, hold_left = 0;
  int n_words = 0, n_results = 0, n_errors = 0, n_draws = 0, n_bad = 0;
  int quiet = 0;

  function automatic void shadow_reset();
    foreach (sh_mem[i]) sh_mem[i] = 8'h00;
    for (int i = 0; i < FONT_LEN; i++) sh_mem[int'(FONT_BASE) + i] = FONT[i];
    foreach (sh_v[i]) sh_v[i] = 8'h00;
    foreach (sh_stack[i]) sh_stack[i] = '0;
    foreach (sh_fb[i]) sh_fb[i] = '0;
    sh_sp = '0;
    sh_pc = PC_START;
    sh_idx = '0;
    sh_delay = '0;
    sh_sound = '0;
  endfunction

  function automatic status_t core_step(input logic [1:0] op, input logic [11:0] addr,
                                        input logic [7:0] data, input logic [15:0] keys,
                                        input logic [7:0] rb, input logic [4:0] row);
    status_t r;
    logic [15:0] opc;
    logic [3:0] x, y, n;
    logic [7:0] nn, a, b, ln;
    logic [11:0] nnn, npc, ad;
    logic [8:0] sum;
    logic [4:0] yy;
    logic [5:0] col;
    logic hit;
    r = '0;
    case (op)
      OP_WRITE: sh_mem[addr] = data;
      OP_ROW:   r.pixels = sh_fb[row];
      OP_EXEC: begin
        opc = {sh_mem[sh_pc], sh_mem[sh_pc + 12'd1]};
        x = opc[11:8]; y = opc[7:4]; n = opc[3:0]; nn = opc[7:0]; nnn = opc[11:0];
        npc = sh_pc + 12'd2;
        a = sh_v[x]; b = sh_v[y];
        case (opc[15:12])
          G_SYS: begin
            if (opc == OPC_CLS) begin
              foreach (sh_fb[i]) sh_fb[i] = '0;
              r.draw = 1'b1;
            end else if (opc == OPC_RET) begin
              sh_sp = sh_sp - 4'd1;
              npc = sh_stack[sh_sp] + 12'd2;
            end else r.bad = 1'b1;
          end
          G_JP: npc = nnn;
          G_CALL: begin
            sh_stack[sh_sp] = sh_pc;
            sh_sp = sh_sp + 4'd1;
            npc = nnn;
          end
          G_SEQ:  if (a == nn) npc = sh_pc + 12'd4;
          G_SNE:  if (a != nn) npc = sh_pc + 12'd4;
          G_SEQR: if (a == b) npc = sh_pc + 12'd4;
          G_SNER: if (a != b) npc = sh_pc + 12'd4;
          G_LD:   sh_v[x] = nn;
          G_ADD:  sh_v[x] = a + nn;
          G_ALU: begin
            case (n)
              A_MOV: sh_v[x] = b;
              A_OR:  sh_v[x] = a | b;
              A_AND: sh_v[x] = a & b;
              A_XOR: sh_v[x] = a ^ b;
              A_ADD: begin
                sum = {1'b0, a} + b;
                sh_v[x] = sum[7:0]; sh_v[15] = {7'd0, sum[8]};
              end
              A_SUB:  begin sh_v[x] = a - b; sh_v[15] = {7'd0, a >= b}; end
              A_SHR:  begin sh_v[x] = a >> 1; sh_v[15] = {7'd0, a[0]}; end
              A_SUBN: begin sh_v[x] = b - a; sh_v[15] = {7'd0, b >= a}; end
              A_SHL:  begin sh_v[x] = a << 1; sh_v[15] = {7'd0, a[7]}; end
              default: r.bad = 1'b1;
            endcase
          end
          G_LDI: sh_idx = {4'd0, nnn};
          G_JPV: npc = nnn + {4'd0, sh_v[0]};
          G_RND: sh_v[x] = rb & nn;
          G_DRW: begin
            hit = 1'b0;
            for (int i = 0; i < n; i++) begin
              ad = sh_idx[11:0] + 12'(i);
              ln = sh_mem[ad];
              yy = b[4:0] + 5'(i);
              for (int c = 0; c < 8; c++) begin
                if (ln[7-c]) begin
                  col = a[5:0] + 6'(c);
                  if (sh_fb[yy][col]) hit = 1'b1;
                  sh_fb[yy][col] = ~sh_fb[yy][col];
                end
              end
            end
            sh_v[15] = {7'd0, hit};
            r.draw = 1'b1;
          end
          G_KEY: begin
            if (nn == K_SKP) begin
              if (keys[a[3:0]]) npc = sh_pc + 12'd4;
            end else if (nn == K_SKNP) begin
              if (!keys[a[3:0]]) npc = sh_pc + 12'd4;
            end else r.bad = 1'b1;
          end
          default: begin
            case (nn)
              M_GDT: sh_v[x] = sh_delay;
              M_WKEY: begin
                if (keys == 16'd0) begin
                  r.waiting = 1'b1;
                  npc = sh_pc;
                end else
                  for (int i = 0; i < 16; i++) if (keys[i]) sh_v[x] = 8'(i);
              end
              M_SDT:  sh_delay = a;
              M_SST:  sh_sound = a;
              M_ADDI: sh_idx = sh_idx + {8'd0, a};
              M_FONT: sh_idx = {8'd0, a} * 16'd5 + {4'd0, FONT_BASE};
              M_BCD: begin
                sh_mem[sh_idx[11:0]] = a / 8'd100;
                sh_mem[sh_idx[11:0] + 12'd1] = (a / 8'd10) % 8'd10;
                sh_mem[sh_idx[11:0] + 12'd2] = a % 8'd10;
              end
              M_STR: for (int i = 0; i <= x; i++) sh_mem[sh_idx[11:0] + 12'(i)] = sh_v[i];
              M_LDR: for (int i = 0; i <= x; i++) sh_v[i] = sh_mem[sh_idx[11:0] + 12'(i)];
              default: r.bad = 1'b1;
            endcase
          end
        endcase
        if (r.bad) npc = sh_pc;
        sh_pc = npc;
      end
      default: ;
    endcase
    r.pc = sh_pc;
    r.sound = (sh_sound != 8'd0);
    return r;
  endfunction

  // one input word; prediction is made in issue order, which is accept order
  task automatic put_word(input logic [1:0] op, input logic [11:0] addr,
                          input logic [7:0] data, input logic [15:0] keys,
                          input logic [7:0] rb, input logic [4:0] row,
                          input bit typed = 1'b0, input status_t typed_res = '0);
    status_t r;
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_address <= addr;
    in_data <= data;
    in_keys <= keys;
    in_random_byte <= rb;
    in_row <= row;
    r = core_step(op, addr, data, keys, rb, row);
    status_due.push_back(typed ? typed_res : r);
    do @(posedge clk); while (in_stall);
    n_words++;
  endtask

  // load an opcode at the live pc, then run it
  task automatic run_opcode(input logic [15:0] opc, input logic [15:0] keys,
                            input logic [7:0] rb, input bit typed = 1'b0,
                            input status_t typed_res = '0);
    put_word(OP_WRITE, sh_pc, opc[15:8], 16'($urandom), 8'($urandom), 5'($urandom));
    put_word(OP_WRITE, sh_pc + 12'd1, opc[7:0], 16'($urandom), 8'($urandom),
             5'($urandom));
    put_word(OP_EXEC, 12'($urandom), 8'($urandom), keys, rb, 5'($urandom), typed,
             typed_res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_opcode();
    logic [15:0] w;
    logic [7:0] fx [9];
    fx = '{M_GDT, M_WKEY, M_SDT, M_SST, M_ADDI, M_FONT, M_BCD, M_STR, M_LDR};
    w = 16'($urandom);
    case (w[15:12])
      G_SYS: if ($urandom_range(9) < 8) w = $urandom_range(1) ? OPC_CLS : OPC_RET;
      G_JP, G_CALL, G_JPV:
        if ($urandom_range(9) == 0) w[11:0] = 12'hFF0 | 12'($urandom_range(15));
      G_ALU: if ($urandom_range(9) < 8) begin
        w[3:0] = 4'($urandom_range(8));
        if (w[3:0] == 4'd8) w[3:0] = A_SHL;
      end
      G_KEY: if ($urandom_range(9) < 8) w[7:0] = $urandom_range(1) ? K_SKP : K_SKNP;
      G_MISC: if ($urandom_range(9) < 8) w[7:0] = fx[$urandom_range(8)];
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] rand_keys();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'd1 << $urandom_range(15);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count);
    int stop, pick;
    stop = n_words + count;
    while (n_words < stop) begin
      pick = $urandom_range(99);
      if (pick < 70)
        run_opcode(rand_opcode(), rand_keys(), 8'($urandom));
      else if (pick < 80)
        put_word(OP_ROW, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                 5'($urandom));
      else if (pick < 88)
        put_word(OP_WRITE, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                 5'($urandom));
      else if (pick < 95)
        put_word(OP_EXEC, 12'($urandom), 8'($urandom), rand_keys(), 8'($urandom),
                 5'($urandom));
      else
        put_word(OP_NONE, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                 5'($urandom));
    end
  endtask

  // result side: stall pattern and compare
  always @(posedge clk) begin
    status_t e;
    if (out_valid && !out_stall) begin
      n_results++;
      if (status_due.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        e = status_due.pop_front();
        if (out_row_pixels !== e.pixels) begin
          $error("row_pixels exp %h got %h", e.pixels, out_row_pixels); n_errors++;
        end
        if (out_program_counter !== e.pc) begin
          $error("program_counter exp %h got %h", e.pc, out_program_counter); n_errors++;
        end
        if (out_draw_flag !== e.draw) begin
          $error("draw_flag exp %b got %b", e.draw, out_draw_flag); n_errors++;
        end
        if (out_waiting_for_key !== e.waiting) begin
          $error("waiting_for_key exp %b got %b", e.waiting, out_waiting_for_key);
          n_errors++;
        end
        if (out_bad_opcode !== e.bad) begin
          $error("bad_opcode exp %b got %b", e.bad, out_bad_opcode); n_errors++;
        end
        if (out_sound_on !== e.sound) begin
          $error("sound_on exp %b got %b", e.sound, out_sound_on); n_errors++;
        end
        n_draws += e.draw;
        n_bad += e.bad;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else
      out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  dir_row_t dir_tab [] = '{
    '{OP_ROW,  16'h0000, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  1, PC_START, 0},
    '{OP_ROW,  16'h0000, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd31, 1, PC_START, 0},
    '{OP_NONE, 16'h0000, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd31, 1, PC_START, 0},
    '{OP_EXEC, 16'h0123, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  1, PC_START, 1},
    '{OP_WRITE,16'h0000, 12'hFFF, 8'hFF, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h6AFF, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h6B01, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h8AB4, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h8AB5, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h8BA7, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h6F81, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h8FFE, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h8FF6, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h8AB8, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hAFFE, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h6C3E, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hDCCF, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hDCCF, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hF00A, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hF00A, 12'h000, 8'h00, 16'h8001, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hE09E, 12'h000, 8'h00, 16'h8000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hE0A1, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hCFFF, 12'h000, 8'h00, 16'h0000, 8'hA5, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hFF18, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hFF33, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'hFFFF, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h2FFE, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h00EE, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0},
    '{OP_EXEC, 16'h00E0, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0,  0, 12'h0, 0}
  };

  initial begin
    status_t t;
    shadow_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    foreach (dir_tab[i]) begin
      t = '0;
      t.pc = dir_tab[i].epc;
      t.bad = dir_tab[i].ebad;
      if (dir_tab[i].op == OP_EXEC)
        run_opcode(dir_tab[i].opc, dir_tab[i].keys, dir_tab[i].rb, dir_tab[i].typed, t);
      else
        put_word(dir_tab[i].op, dir_tab[i].addr, dir_tab[i].data, dir_tab[i].keys,
                 dir_tab[i].rb, dir_tab[i].row, dir_tab[i].typed, t);
    end
    drain();

    tx_idle_pct = 30; rx_idle_pct = 88;
    random_phase(N_RANDOM / 6);
    // long receiver hold while words keep coming in
    hold_left = 400;
    random_phase(N_RANDOM / 6);
    drain();

    tx_idle_pct = 88; rx_idle_pct = 30;
    random_phase(N_RANDOM / 3);
    drain();

    tx_idle_pct = 0; rx_idle_pct = 0;
    random_phase(N_RANDOM / 3);
    drain();
    repeat (100) @(posedge clk);

    $display("run covered %0d input words, %0d result words", n_words, n_results);
    $display("  including %0d screen updates and %0d unknown opcodes", n_draws, n_bad);
    if (n_errors == 0 && status_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
